>>> src/acss_pkg.sv
// Shared types and constants of the ADC channel scan sequencer.
package acss_pkg;

  localparam int CHAN_W = 4;
  localparam int SAMPLE_W = 12;
  localparam int MASK_W = 16;
  localparam int WIDE_W = 16;

  localparam logic [MASK_W-1:0] MASK_RESET = 16'h8000;

  typedef logic [CHAN_W-1:0] chan_t;
  typedef logic [SAMPLE_W-1:0] sample_t;
  typedef logic [MASK_W-1:0] mask_t;
  typedef logic [WIDE_W-1:0] wide_t;

  localparam logic CMD_CONVERT = 1'b0;
  localparam logic CMD_READ = 1'b1;

endpackage

>>> src/adc_channel_scan_sequencer.sv
// Top level of the ADC channel scan sequencer: round-robin scan control and result table.
//
// Usage: pulse start with cmd, sample_value and read_channel while busy is low to issue a
// transaction. A convert transaction (cmd 0) stores sample_value for the current channel and
// searches, wrapping, for the next enabled channel; a read transaction (cmd 1) returns the
// stored sample of read_channel. Each transaction yields one result, shown on start_channel
// and read_value for exactly one cycle while done is high. The receiver cannot stall.
// The enable mask is written through cfg_wr_en and cfg_wr_data; the user must write it only
// while the block is idle, which the block itself does not enforce. The highest channel is
// always treated as enabled. A read is answered from the read state, which raises done; a
// convert steps through the search state, which tests one channel per cycle with a single
// increment-and-test unit until it reaches an enabled channel. busy stays high until done is
// raised, and the next transaction can be accepted in the cycle done is high.
// Reset sets the mask to only the reference channel, the current channel to the highest
// channel and marks every table entry empty, so empty entries read as zero. There is no
// clearing pass.
module adc_channel_scan_sequencer #(
  parameter int NUM_CHANNELS = 16,
  parameter int SAMPLE_BITS = 12
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  logic             cmd,
  input  acss_pkg::sample_t sample_value,
  input  acss_pkg::chan_t  read_channel,
  output logic             done,
  output acss_pkg::chan_t  start_channel,
  output acss_pkg::sample_t read_value,
  input  logic             cfg_wr_en,
  input  acss_pkg::mask_t  cfg_wr_data
);
  import acss_pkg::*;

  localparam int IDX_W = $clog2(NUM_CHANNELS);
  localparam chan_t REF_CH = CHAN_W'(NUM_CHANNELS - 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SEARCH = 2'd1;
  localparam logic [1:0] ST_READ = 2'd2;

  logic [1:0] state;
  mask_t channel_enable_mask;
  chan_t current_channel;
  chan_t probe;
  chan_t read_ch;
  logic [NUM_CHANNELS-1:0] entry_valid;
  logic [SAMPLE_BITS-1:0] channel_results [NUM_CHANNELS];

  mask_t mask_eff;
  chan_t probe_next;
  logic probe_hit;
  logic accept;
  wide_t sample_wide;
  logic read_in_range;

  assign busy = (state != ST_IDLE);
  assign accept = start && !busy;
  assign mask_eff = channel_enable_mask | (MASK_W'(1) << REF_CH);
  assign probe_next = (probe >= REF_CH) ? '0 : probe + 1'b1;
  assign probe_hit = mask_eff[probe_next];
  assign sample_wide = WIDE_W'(sample_value);
  assign read_in_range = (read_ch <= REF_CH);

  always_ff @(posedge clk) begin
    if (rst) begin
      channel_enable_mask <= MASK_RESET;
    end else if (cfg_wr_en) begin
      channel_enable_mask <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && cmd == CMD_CONVERT) begin
      channel_results[current_channel[IDX_W-1:0]] <= sample_wide[SAMPLE_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
    end else if (accept && cmd == CMD_CONVERT) begin
      entry_valid[current_channel[IDX_W-1:0]] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      probe <= current_channel;
      read_ch <= read_channel;
    end else if (state == ST_SEARCH) begin
      probe <= probe_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      current_channel <= REF_CH;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (accept) begin
            state <= (cmd == CMD_READ) ? ST_READ : ST_SEARCH;
          end
        end
        ST_SEARCH: begin
          if (probe_hit) begin
            current_channel <= probe_next;
            done <= 1'b1;
            state <= ST_IDLE;
          end
        end
        ST_READ: begin
          done <= 1'b1;
          state <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_SEARCH: begin
        start_channel <= probe_next;
        read_value <= '0;
      end
      ST_READ: begin
        start_channel <= current_channel;
        if (read_in_range && entry_valid[read_ch[IDX_W-1:0]]) begin
          read_value <= SAMPLE_W'(channel_results[read_ch[IDX_W-1:0]]);
        end else begin
          read_value <= '0;
        end
      end
      default: begin
        start_channel <= start_channel;
        read_value <= read_value;
      end
    endcase
  end

  a_done_after_work: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result strobe without a transaction in progress");

  a_done_current: assert property (@(posedge clk) disable iff (rst)
    done |-> start_channel == current_channel)
    else $error("reported channel differs from the current channel");

  a_channel_range: assert property (@(posedge clk) disable iff (rst)
    current_channel <= REF_CH)
    else $error("current channel out of range");

  a_search_ends: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SEARCH && probe_next == REF_CH) |=> state == ST_IDLE)
    else $error("search passed the reference channel");

  a_convert_zero: assert property (@(posedge clk) disable iff (rst)
    (done && $past(state) == ST_SEARCH) |-> read_value == '0)
    else $error("convert result carries a nonzero read value");

endmodule

>>> test/adc_channel_scan_sequencer_tb.sv
// Self-checking testbench for the ADC channel scan sequencer: directed and random transactions.
`timescale 1ns / 1ps

module adc_channel_scan_sequencer_tb;
  import acss_pkg::*;

  localparam int NUM_CH = 16;
  localparam chan_t REF_CHAN = 4'd15;
  localparam int CYCLE_LIMIT = 200000;
  localparam int RANDOM_PER_PHASE = 130;

  typedef struct {
    chan_t start_channel;
    sample_t read_value;
  } scan_result_t;

  class scan_scoreboard;
    mask_t enable_mask;
    chan_t current_chan;
    sample_t stored[NUM_CH];
    scan_result_t expected_results[$];
    int errors;
    int conversions;
    int reads;
    int mask_writes;

    function new();
      enable_mask = MASK_RESET;
      current_chan = REF_CHAN;
      foreach (stored[i]) stored[i] = '0;
      errors = 0;
      conversions = 0;
      reads = 0;
      mask_writes = 0;
    endfunction

    function void write_mask(mask_t m);
      enable_mask = m;
      mask_writes++;
    endfunction

    function chan_t next_scan_channel(chan_t from);
      chan_t n = from;
      for (int i = 0; i < NUM_CH; i++) begin
        n = n + 1'b1;
        if (n == REF_CHAN || enable_mask[n]) return n;
      end
      return REF_CHAN;
    endfunction

    function void note_transaction(logic c, sample_t s, chan_t rch);
      scan_result_t r;
      r.read_value = '0;
      if (c == CMD_CONVERT) begin
        stored[current_chan] = s;
        current_chan = next_scan_channel(current_chan);
        conversions++;
      end else begin
        r.read_value = stored[rch];
        reads++;
      end
      r.start_channel = current_chan;
      expected_results.push_back(r);
    endfunction

    function void check_result(chan_t sc, sample_t rv);
      scan_result_t r;
      if (expected_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result: start_channel %0d read_value %0d", $time, sc, rv);
        return;
      end
      r = expected_results.pop_front();
      if (sc !== r.start_channel) begin
        errors++;
        $display("%0t: start_channel mismatch: expected %0d, actual %0d",
                 $time, r.start_channel, sc);
      end
      if (rv !== r.read_value) begin
        errors++;
        $display("%0t: read_value mismatch: expected %0d, actual %0d",
                 $time, r.read_value, rv);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic cmd = CMD_CONVERT;
  sample_t sample_value = '0;
  chan_t read_channel = '0;
  logic done;
  chan_t start_channel;
  sample_t read_value;
  logic cfg_wr_en = 1'b0;
  mask_t cfg_wr_data = '0;

  scan_scoreboard sb = new();
  int cycles = 0;

  adc_channel_scan_sequencer #(
    .NUM_CHANNELS(NUM_CH),
    .SAMPLE_BITS(SAMPLE_W)
  ) dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .cmd(cmd),
    .sample_value(sample_value),
    .read_channel(read_channel),
    .done(done),
    .start_channel(start_channel),
    .read_value(read_value),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles.", cycles);
      $display("** adc_channel_scan_sequencer: FAILED **");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && done) sb.check_result(start_channel, read_value);
  end

  task automatic issue_transaction(input logic c, input sample_t s, input chan_t rch);
    @(negedge clk);
    start <= 1'b1;
    cmd <= c;
    sample_value <= s;
    read_channel <= rch;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    sb.note_transaction(c, s, rch);
  endtask

  task automatic hold_off(input int n);
    @(negedge clk);
    start <= 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  task automatic drain();
    @(negedge clk);
    start <= 1'b0;
    while (sb.expected_results.size() != 0 || busy) @(negedge clk);
  endtask

  task automatic write_enable_mask(input mask_t m);
    drain();
    repeat (3) @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= m;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    sb.write_mask(m);
  endtask

  initial begin
    mask_t phase_masks[6];
    int idle_pct;
    int gap;
    logic c;
    sample_t s;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    issue_transaction(CMD_READ, 12'h000, 4'd0);
    issue_transaction(CMD_READ, 12'hfff, 4'd15);
    issue_transaction(CMD_CONVERT, 12'hfff, 4'd0);
    issue_transaction(CMD_READ, 12'h000, 4'd15);
    issue_transaction(CMD_CONVERT, 12'h000, 4'd15);
    issue_transaction(CMD_READ, 12'h000, 4'd15);

    write_enable_mask(16'hffff);
    issue_transaction(CMD_CONVERT, 12'habc, 4'd0);
    issue_transaction(CMD_CONVERT, 12'h555, 4'd0);
    issue_transaction(CMD_CONVERT, 12'haaa, 4'd0);
    issue_transaction(CMD_CONVERT, 12'hfff, 4'd0);
    issue_transaction(CMD_READ, 12'h000, 4'd0);
    issue_transaction(CMD_READ, 12'h000, 4'd1);
    issue_transaction(CMD_READ, 12'h000, 4'd2);
    issue_transaction(CMD_READ, 12'h000, 4'd15);

    write_enable_mask(16'h0000);
    issue_transaction(CMD_CONVERT, 12'h123, 4'd0);
    issue_transaction(CMD_CONVERT, 12'h001, 4'd0);
    issue_transaction(CMD_READ, 12'h000, 4'd3);
    issue_transaction(CMD_READ, 12'h000, 4'd15);

    write_enable_mask(16'h0001);
    issue_transaction(CMD_CONVERT, 12'h800, 4'd0);
    issue_transaction(CMD_CONVERT, 12'h7ff, 4'd0);
    issue_transaction(CMD_READ, 12'h000, 4'd0);

    phase_masks[0] = mask_t'($urandom_range(16'hffff));
    phase_masks[1] = 16'h0000;
    phase_masks[2] = 16'hffff;
    phase_masks[3] = 16'h4001;
    phase_masks[4] = 16'h7fff;
    phase_masks[5] = mask_t'($urandom_range(16'hffff));

    for (int p = 0; p < 6; p++) begin
      idle_pct = (p < 2) ? 30 : (p < 4) ? 55 : 0;
      write_enable_mask(phase_masks[p]);
      for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
        gap = 0;
        while (gap < 20 && $urandom_range(99) < idle_pct) gap++;
        if (gap > 0) hold_off(gap);
        if ($urandom_range(63) == 0) drain();
        c = ($urandom_range(99) < 65) ? CMD_CONVERT : CMD_READ;
        case ($urandom_range(7))
          0: s = '0;
          1: s = '1;
          default: s = sample_t'($urandom_range(4095));
        endcase
        issue_transaction(c, s, chan_t'($urandom_range(15)));
      end
    end

    hold_off(1);
    while (sb.expected_results.size() != 0 || busy) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Covered %0d transactions: %0d conversions and %0d reads.",
             sb.conversions + sb.reads, sb.conversions, sb.reads);
    $display("Used %0d enable-mask writes, empty and full masks included, with sender idling.",
             sb.mask_writes);
    if (sb.errors == 0) begin
      $display("** adc_channel_scan_sequencer: PASSED **");
    end else begin
      $display("** adc_channel_scan_sequencer: FAILED **");
    end
    $finish;
  end

endmodule

>>> files.f
src/acss_pkg.sv
src/adc_channel_scan_sequencer.sv
test/adc_channel_scan_sequencer_tb.sv
